/* hw/rtl/multiplexed_bcd_clock_with_set_buttons_top_macros.svh */
// assertion macros for the multiplexed bcd clock top level
`ifndef MULTIPLEXED_BCD_CLOCK_WITH_SET_BUTTONS_TOP_MACROS_SVH
`define MULTIPLEXED_BCD_CLOCK_WITH_SET_BUTTONS_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define MBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define MBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mbc_pkg.sv */
// shared types, constants and segment decode for the bcd clock
`default_nettype none

package mbc_pkg;

	// display digit codes, in scan order
	localparam logic [2:0] DIG_HOUR_TENS   = 3'd0;
	localparam logic [2:0] DIG_HOUR_UNITS  = 3'd1;
	localparam logic [2:0] DIG_MIN_TENS    = 3'd2;
	localparam logic [2:0] DIG_MIN_UNITS   = 3'd3;
	localparam logic [2:0] DIG_SEC_TENS    = 3'd4;
	localparam logic [2:0] DIG_SEC_UNITS   = 3'd5;
	localparam logic [2:0] DIG_TENTHS      = 3'd6;

	// button bit positions in the latched level word
	localparam int BTN_HOUR   = 0;
	localparam int BTN_MINUTE = 1;
	localparam int BTN_SECOND = 2;
	localparam int BTN_SET    = 3;

	// register byte address of the debounce gap
	localparam logic [1:0] ADDR_GAP = 2'd0;

	// counter limits
	localparam logic [7:0] CS_LIMIT         = 8'd100;
	localparam logic [4:0] UNIT_LIMIT       = 5'd10;
	localparam logic [3:0] TENS_LIMIT       = 4'd6;
	localparam logic [1:0] HOUR_TENS_LIMIT  = 2'd2;
	localparam logic [3:0] HOUR_UNITS_LIMIT = 4'd4;

	// reset values
	localparam logic [7:0] GAP_RESET    = 8'd10;
	localparam logic [3:0] LEVELS_RESET = 4'hF;

	// centiseconds / 10 as multiply by 205 and shift by 11 (exact below 180)
	localparam logic [14:0] TENTHS_RECIP = 15'd205;

	typedef struct packed {
		logic [1:0] ht;
		logic [3:0] hu;
		logic [2:0] mt;
		logic [3:0] mu;
		logic [2:0] st;
		logic [3:0] su;
		logic [6:0] cs;
	} mbc_time_t;

	typedef struct packed {
		logic tick;
		logic hour;
		logic minute;
		logic second;
	} mbc_bump_t;

	typedef struct packed {
		logic       setting;
		logic [2:0] digit;
	} mbc_scan_stat_t;

	// seven-segment pattern, bit0 = a .. bit6 = g, dark above nine
	function automatic logic [6:0] seg_of(input logic [3:0] v);
		logic [6:0] s;
		case (v)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/mbc_time_core.sv */
// bcd time-of-day counter with eager carries and 24-hour wrap
`default_nettype none

module mbc_time_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbc_pkg::mbc_bump_t bump,
	output mbc_pkg::mbc_time_t     time_now
);

	mbc_pkg::mbc_time_t time_q;
	mbc_pkg::mbc_time_t time_n;

	logic [7:0] cs_sum;
	logic [4:0] su_sum;
	logic [3:0] st_sum;
	logic [4:0] mu_sum;
	logic [3:0] mt_sum;
	logic [4:0] hu_sum;
	logic       sec_inc;
	logic       min_inc;
	logic       hr_inc;
	logic [3:0] h_units;
	logic [1:0] h_tens;

	// single increments of each digit
	assign cs_sum = {1'b0, time_q.cs} + 8'd1;
	assign su_sum = {1'b0, time_q.su} + 5'd1;
	assign st_sum = {1'b0, time_q.st} + 4'd1;
	assign mu_sum = {1'b0, time_q.mu} + 5'd1;
	assign mt_sum = {1'b0, time_q.mt} + 4'd1;
	assign hu_sum = {1'b0, time_q.hu} + 5'd1;

	// carry ripple from centiseconds up to hours
	always_comb begin
		time_n  = time_q;
		sec_inc = bump.second;
		min_inc = bump.minute;
		hr_inc  = bump.hour;
		h_units = time_q.hu;
		h_tens  = time_q.ht;

		if (bump.tick) begin
			if (cs_sum >= mbc_pkg::CS_LIMIT) begin
				time_n.cs = '0;
				sec_inc   = 1'b1;
			end else begin
				time_n.cs = cs_sum[6:0];
			end
		end

		if (sec_inc) begin
			if (su_sum >= mbc_pkg::UNIT_LIMIT) begin
				time_n.su = '0;
				if (st_sum >= mbc_pkg::TENS_LIMIT) begin
					time_n.st = '0;
					min_inc   = 1'b1;
				end else begin
					time_n.st = st_sum[2:0];
				end
			end else begin
				time_n.su = su_sum[3:0];
			end
		end

		if (min_inc) begin
			if (mu_sum >= mbc_pkg::UNIT_LIMIT) begin
				time_n.mu = '0;
				if (mt_sum >= mbc_pkg::TENS_LIMIT) begin
					time_n.mt = '0;
					hr_inc    = 1'b1;
				end else begin
					time_n.mt = mt_sum[2:0];
				end
			end else begin
				time_n.mu = mu_sum[3:0];
			end
		end

		if (hr_inc) begin
			if (hu_sum >= mbc_pkg::UNIT_LIMIT) begin
				h_units = '0;
				h_tens  = time_q.ht + 2'd1;
			end else begin
				h_units = hu_sum[3:0];
			end
			// 24:00 wraps to 00:00
			if (h_tens >= mbc_pkg::HOUR_TENS_LIMIT && h_units >= mbc_pkg::HOUR_UNITS_LIMIT) begin
				h_units = '0;
				h_tens  = '0;
			end
			time_n.hu = h_units;
			time_n.ht = h_tens;
		end
	end

	// time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else begin
			time_q <= time_n;
		end
	end

	assign time_now = time_q;

endmodule

`default_nettype wire

/* hw/rtl/mbc_scan_ctrl.sv */
// scan digit, button latching, debounce and set-mode control
`default_nettype none

module mbc_scan_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  scan_go,
	input  wire logic                  tick_go,
	input  wire logic [31:0]           now_s1,
	input  wire logic [3:0]            levels_s1,
	input  wire logic [7:0]            gap,
	output mbc_pkg::mbc_scan_stat_t    stat,
	output mbc_pkg::mbc_bump_t         bump
);

	logic        setting_q;
	logic [2:0]  digit_q;
	logic [1:0]  slot_q;
	logic [3:0]  latched_q;
	logic [31:0] last_press_q;

	logic [3:0]  latched_n;
	logic [31:0] elapsed;
	logic        gap_ok;
	logic        set_p;
	logic        hour_p;
	logic        min_p;
	logic        sec_p;
	logic        setting_n;
	logic        press_seen;

	// latch one pin level in rotation
	always_comb begin
		latched_n         = latched_q;
		latched_n[slot_q] = levels_s1[slot_q];
	end

	// debounce test against the last recorded press
	assign elapsed = now_s1 - last_press_q;
	assign gap_ok  = elapsed > {24'd0, gap};

	assign set_p  = !latched_n[mbc_pkg::BTN_SET];
	assign hour_p = !latched_n[mbc_pkg::BTN_HOUR];
	assign min_p  = !latched_n[mbc_pkg::BTN_MINUTE];
	assign sec_p  = !latched_n[mbc_pkg::BTN_SECOND];

	// set button goes first; a press after it in the same scan sees no gap
	assign setting_n  = setting_q ^ (set_p & gap_ok);
	assign press_seen = set_p | (setting_n & (hour_p | min_p | sec_p));

	always_comb begin
		bump        = '0;
		bump.tick   = tick_go & !setting_q;
		if (scan_go && setting_n && !set_p && gap_ok) begin
			bump.hour   = hour_p;
			bump.minute = !hour_p & min_p;
			bump.second = !hour_p & !min_p & sec_p;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q    <= 1'b0;
			digit_q      <= mbc_pkg::DIG_HOUR_TENS;
			slot_q       <= '0;
			latched_q    <= mbc_pkg::LEVELS_RESET;
			last_press_q <= '0;
		end else if (scan_go) begin
			setting_q <= setting_n;
			digit_q   <= (digit_q >= mbc_pkg::DIG_TENTHS) ? mbc_pkg::DIG_HOUR_TENS
				: digit_q + 3'd1;
			slot_q    <= slot_q + 2'd1;
			latched_q <= latched_n;
			if (press_seen) begin
				last_press_q <= now_s1;
			end
		end
	end

	assign stat.setting = setting_q;
	assign stat.digit   = digit_q;

endmodule

`default_nettype wire

/* hw/rtl/mbc_disp.sv */
// digit select, segment decode and result register
`default_nettype none

module mbc_disp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    scan_go,
	input  wire mbc_pkg::mbc_scan_stat_t stat,
	input  wire mbc_pkg::mbc_time_t      time_now,
	input  wire logic                    result_stall,
	output logic                         result_valid,
	output logic [2:0]                   digit_select,
	output logic [6:0]                   segments,
	output logic                         set_mode_on
);

	logic        valid_q;
	logic [2:0]  digit_q;
	logic [6:0]  seg_q;
	logic        set_q;

	logic [14:0] tenths_prod;
	logic [3:0]  tenths;
	logic [3:0]  shown;
	logic        dark;
	logic [6:0]  seg_n;

	// tenths of a second from the centisecond count
	assign tenths_prod = {8'd0, time_now.cs} * mbc_pkg::TENTHS_RECIP;
	assign tenths      = tenths_prod[14:11];

	// pick the digit under the scan
	always_comb begin
		dark  = 1'b0;
		shown = '0;
		case (stat.digit)
			mbc_pkg::DIG_HOUR_TENS:  shown = {2'd0, time_now.ht};
			mbc_pkg::DIG_HOUR_UNITS: shown = time_now.hu;
			mbc_pkg::DIG_MIN_TENS:   shown = {1'b0, time_now.mt};
			mbc_pkg::DIG_MIN_UNITS:  shown = time_now.mu;
			mbc_pkg::DIG_SEC_TENS:   shown = {1'b0, time_now.st};
			mbc_pkg::DIG_SEC_UNITS:  shown = time_now.su;
			mbc_pkg::DIG_TENTHS:     shown = tenths;
			default:                 dark  = 1'b1;
		endcase
	end

	assign seg_n = dark ? 7'd0 : mbc_pkg::seg_of(shown);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (scan_go) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (scan_go) begin
			digit_q <= stat.digit;
			seg_q   <= seg_n;
			set_q   <= stat.setting;
		end
	end

	assign result_valid = valid_q;
	assign digit_select = digit_q;
	assign segments     = seg_q;
	assign set_mode_on  = set_q;

endmodule

`default_nettype wire

/* hw/rtl/multiplexed_bcd_clock_with_set_buttons_top.sv */
// Multiplexed 24-hour BCD clock with set buttons. The block takes one request per clock
// cycle, ticks and scan steps alike, whenever item_stall is low. A request taken at a clock
// edge sits in the input register until it can advance; in that cycle a single pass of logic
// advances the time counters and button handling and loads the scan result into the output
// register; the result is offered from then on. Ticks produce no result and never wait.
// The only thing that holds off a new request is the result register: item_stall rises while
// a scan request sits in the input register and the previous result is still held there by
// result_stall. The debounce gap is written through the APB port at address 0.
`default_nettype none
`include "multiplexed_bcd_clock_with_set_buttons_top_macros.svh"

module multiplexed_bcd_clock_with_set_buttons_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        kind,
	input  wire logic [31:0] now_ms,
	input  wire logic        hour_button_level,
	input  wire logic        minute_button_level,
	input  wire logic        second_button_level,
	input  wire logic        set_button_level,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       digit_select,
	output logic [6:0]       segments,
	output logic             set_mode_on,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        valid_s1;
	logic        kind_s1;
	logic [31:0] now_s1;
	logic [3:0]  levels_s1;
	logic [7:0]  gap_q;

	logic        item_take;
	logic        advance;
	logic        scan_go;
	logic        tick_go;
	logic        cfg_write;

	mbc_pkg::mbc_bump_t      bump;
	mbc_pkg::mbc_scan_stat_t stat;
	mbc_pkg::mbc_time_t      time_now;

	// configuration register, single word
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready & (paddr == mbc_pkg::ADDR_GAP);
	assign prdata    = {24'd0, gap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= mbc_pkg::GAP_RESET;
		end else if (cfg_write) begin
			gap_q <= pwdata[7:0];
		end
	end

	// input stage handshake
	assign advance    = valid_s1 & (!kind_s1 | !result_valid | !result_stall);
	assign item_stall = valid_s1 & !advance;
	assign item_take  = item_valid & !item_stall;
	assign scan_go    = advance & kind_s1;
	assign tick_go    = advance & !kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_s1   <= kind;
			now_s1    <= now_ms;
			levels_s1 <= {set_button_level, second_button_level,
				minute_button_level, hour_button_level};
		end
	end

	mbc_scan_ctrl u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_go   (scan_go),
		.tick_go   (tick_go),
		.now_s1    (now_s1),
		.levels_s1 (levels_s1),
		.gap       (gap_q),
		.stat      (stat),
		.bump      (bump)
	);

	mbc_time_core u_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.bump     (bump),
		.time_now (time_now)
	);

	mbc_disp u_disp (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_go      (scan_go),
		.stat         (stat),
		.time_now     (time_now),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.digit_select (digit_select),
		.segments     (segments),
		.set_mode_on  (set_mode_on)
	);

	// checks
	`MBC_ASSERT_NOW(a_stall_only_on_full, item_stall, result_valid && result_stall && kind_s1, "input stalled without a blocked scan result")
	`MBC_ASSERT_NEXT(a_scan_loads_result, scan_go, result_valid, "scan request left no result")
	`MBC_ASSERT_NEXT(a_set_mode_freezes, tick_go && stat.setting, $stable(time_now), "time moved on a tick in set mode")
	`MBC_ASSERT_NOW(a_digits_in_range, 1'b1, time_now.su < 4'd10 && time_now.mu < 4'd10 && time_now.st < 3'd6 && time_now.mt < 3'd6 && time_now.cs < 7'd100, "time digit out of range")

endmodule

`default_nettype wire

/* sim/tb_multiplexed_bcd_clock_with_set_buttons_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the multiplexed bcd clock with set buttons

module tb_multiplexed_bcd_clock_with_set_buttons_top;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_SCAN = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [2:0] digit;
		logic [6:0] seg;
		logic       setm;
	} scan_out_t;

	typedef struct packed {
		req_kind_t   kind;
		logic [31:0] at_ms;
		logic [3:0]  pins;
		logic        typed;
		scan_out_t   frame;
	} stim_row_t;

	localparam logic [1:0] GAP_ADDR     = mbc_pkg::ADDR_GAP;
	localparam logic [6:0] ZERO_GLYPH   = 7'h3F;
	localparam logic [6:0] GLYPHS [10]  = '{ZERO_GLYPH, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
	localparam scan_out_t NO_FRAME      = '0;
	localparam int        DIRECTED_ROWS = 23;
	localparam int        PHASE_ITEMS   = 357;
	localparam int        LONG_HOLD     = 300;
	localparam int        QUIET_LIMIT   = 2000;

	// pins: bit3 set, bit2 second, bit1 minute, bit0 hour; 0 = pressed
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// digits straight after reset, time extremes
		'{KIND_SCAN, 32'h0000_0000, 4'hF, 1'b1, '{mbc_pkg::DIG_HOUR_TENS,  ZERO_GLYPH, 1'b0}},
		'{KIND_SCAN, 32'hFFFF_FFFF, 4'hF, 1'b1, '{mbc_pkg::DIG_HOUR_UNITS, ZERO_GLYPH, 1'b0}},
		'{KIND_TICK, 32'hFFFF_FFFF, 4'h0, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'h0000_0001, 4'hF, 1'b1, '{mbc_pkg::DIG_MIN_TENS,   ZERO_GLYPH, 1'b0}},
		// set pressed in its slot, enters set mode
		'{KIND_SCAN, 32'd11, 4'h7, 1'b1, '{mbc_pkg::DIG_MIN_UNITS, ZERO_GLYPH, 1'b0}},
		// tick while stopped
		'{KIND_TICK, 32'd11, 4'hF, 1'b0, NO_FRAME},
		// latch every button pressed, all presses bounce
		'{KIND_SCAN, 32'd11, 4'h6, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd11, 4'h4, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd11, 4'h0, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd11, 4'h8, 1'b0, NO_FRAME},
		// held buttons after the gap, then exactly at the gap
		'{KIND_SCAN, 32'd22, 4'h0, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd33, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd43, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd54, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd54, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd60, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd60, 4'hF, 1'b0, NO_FRAME},
		// set press near the top of the millisecond range, then across the wrap
		'{KIND_SCAN, 32'hFFFF_FFF0, 4'h7, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd5, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd5, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd5, 4'hF, 1'b0, NO_FRAME},
		'{KIND_SCAN, 32'd5, 4'hF, 1'b0, NO_FRAME},
		'{KIND_TICK, 32'd5, 4'hF, 1'b0, NO_FRAME}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        kind = 1'b0;
	logic [31:0] now_ms = '0;
	logic        hour_button_level = 1'b1;
	logic        minute_button_level = 1'b1;
	logic        second_button_level = 1'b1;
	logic        set_button_level = 1'b1;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  digit_select;
	logic [6:0]  segments;
	logic        set_mode_on;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predicted clock state
	logic [6:0]  clk_cs = '0;
	logic [3:0]  clk_su = '0;
	logic [2:0]  clk_st = '0;
	logic [3:0]  clk_mu = '0;
	logic [2:0]  clk_mt = '0;
	logic [3:0]  clk_hu = '0;
	logic [1:0]  clk_ht = '0;
	logic        stopped_for_set = 1'b0;
	logic [2:0]  shown_digit = mbc_pkg::DIG_HOUR_TENS;
	logic [1:0]  latch_slot = '0;
	logic [3:0]  pin_latch = mbc_pkg::LEVELS_RESET;
	logic [31:0] last_press_at = '0;
	logic [7:0]  gap_cfg = mbc_pkg::GAP_RESET;

	scan_out_t   due_frames [$];
	int          mismatches = 0;
	int          frames_checked = 0;
	int          scans_sent = 0;
	int          ticks_sent = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          long_holds_asked = 0;
	int          long_holds_done = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [31:0] sim_ms = '0;
	int          held_left [4] = '{0, 0, 0, 0};

	multiplexed_bcd_clock_with_set_buttons_top u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.item_valid          (item_valid),
		.item_stall          (item_stall),
		.kind                (kind),
		.now_ms              (now_ms),
		.hour_button_level   (hour_button_level),
		.minute_button_level (minute_button_level),
		.second_button_level (second_button_level),
		.set_button_level    (set_button_level),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.digit_select        (digit_select),
		.segments            (segments),
		.set_mode_on         (set_mode_on),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready)
	);

	always #5 clk = ~clk;

	// time counter carries
	function automatic void bump_hours();
		clk_hu = clk_hu + 4'd1;
		if (clk_hu >= 4'd10) begin
			clk_hu = '0;
			clk_ht = clk_ht + 2'd1;
		end
		if (clk_ht >= 2'd2 && clk_hu >= 4'd4) begin
			clk_hu = '0;
			clk_ht = '0;
		end
	endfunction

	function automatic void bump_minutes();
		clk_mu = clk_mu + 4'd1;
		if (clk_mu >= 4'd10) begin
			clk_mu = '0;
			clk_mt = clk_mt + 3'd1;
			if (clk_mt >= 3'd6) begin
				clk_mt = '0;
				bump_hours();
			end
		end
	endfunction

	function automatic void bump_seconds();
		clk_su = clk_su + 4'd1;
		if (clk_su >= 4'd10) begin
			clk_su = '0;
			clk_st = clk_st + 3'd1;
			if (clk_st >= 3'd6) begin
				clk_st = '0;
				bump_minutes();
			end
		end
	endfunction

	function automatic logic [6:0] glyph_of(input logic [3:0] v);
		return (v < 4'd10) ? GLYPHS[v] : 7'h00;
	endfunction

	// debounce: every press moves the last-press time, accepted or not
	function automatic bit press_ok(input logic [31:0] t);
		logic [31:0] since;
		since = t - last_press_at;
		last_press_at = t;
		return since > {24'd0, gap_cfg};
	endfunction

	// advance the predicted clock by one request, giving the display frame if any
	function automatic void clock_model_step(input req_kind_t k, input logic [31:0] t,
			input logic [3:0] pins, output bit has_frame, output scan_out_t frame);
		logic [3:0] shown;
		logic [6:0] tenths;
		has_frame = 1'b0;
		frame = NO_FRAME;
		if (k == KIND_TICK) begin
			if (!stopped_for_set) begin
				clk_cs = clk_cs + 7'd1;
				if (clk_cs >= 7'd100) begin
					clk_cs = '0;
					bump_seconds();
				end
			end
			return;
		end
		tenths = clk_cs / 7'd10;
		case (shown_digit)
			mbc_pkg::DIG_HOUR_TENS:  shown = {2'b00, clk_ht};
			mbc_pkg::DIG_HOUR_UNITS: shown = clk_hu;
			mbc_pkg::DIG_MIN_TENS:   shown = {1'b0, clk_mt};
			mbc_pkg::DIG_MIN_UNITS:  shown = clk_mu;
			mbc_pkg::DIG_SEC_TENS:   shown = {1'b0, clk_st};
			mbc_pkg::DIG_SEC_UNITS:  shown = clk_su;
			mbc_pkg::DIG_TENTHS:     shown = tenths[3:0];
			default:                 shown = 4'hF;
		endcase
		has_frame = 1'b1;
		frame.digit = shown_digit;
		frame.seg = glyph_of(shown);
		frame.setm = stopped_for_set;
		shown_digit = (shown_digit >= mbc_pkg::DIG_TENTHS) ? mbc_pkg::DIG_HOUR_TENS
			: shown_digit + 3'd1;
		pin_latch[latch_slot] = pins[latch_slot];
		latch_slot = latch_slot + 2'd1;
		// set button first, then the field buttons while setting
		if (!pin_latch[mbc_pkg::BTN_SET]) begin
			if (press_ok(t))
				stopped_for_set = !stopped_for_set;
		end
		if (stopped_for_set) begin
			if (!pin_latch[mbc_pkg::BTN_HOUR]) begin
				if (press_ok(t))
					bump_hours();
			end
			if (!pin_latch[mbc_pkg::BTN_MINUTE]) begin
				if (press_ok(t))
					bump_minutes();
			end
			if (!pin_latch[mbc_pkg::BTN_SECOND]) begin
				if (press_ok(t))
					bump_seconds();
			end
		end
	endfunction

	// drive one request, wait for it to be taken, then idle cycle by cycle
	task automatic offer_request(input req_kind_t k, input logic [31:0] t,
			input logic [3:0] pins, input logic typed, input scan_out_t typed_frame);
		bit        has_frame;
		scan_out_t frame;
		kind <= k;
		now_ms <= t;
		hour_button_level <= pins[mbc_pkg::BTN_HOUR];
		minute_button_level <= pins[mbc_pkg::BTN_MINUTE];
		second_button_level <= pins[mbc_pkg::BTN_SECOND];
		set_button_level <= pins[mbc_pkg::BTN_SET];
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		clock_model_step(k, t, pins, has_frame, frame);
		if (has_frame) begin
			due_frames.push_back(typed ? typed_frame : frame);
			scans_sent++;
		end else begin
			ticks_sent++;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// random request: a drifting millisecond clock and buttons held over runs
	task automatic next_random_request(output req_kind_t k, output logic [31:0] t,
			output logic [3:0] pins);
		int r;
		int b;
		k = ($urandom_range(0, 99) < 55) ? KIND_SCAN : KIND_TICK;
		r = $urandom_range(0, 99);
		if (r < 3)
			sim_ms = $urandom;
		else if (r < 5)
			sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
		else
			sim_ms = sim_ms + $urandom_range(0, 2 * gap_cfg + 4);
		t = sim_ms;
		for (b = 0; b < 4; b++) begin
			if (held_left[b] > 0) begin
				pins[b] = 1'b0;
				held_left[b]--;
			end else begin
				pins[b] = 1'b1;
				if ($urandom_range(0, (b == mbc_pkg::BTN_SET) ? 24 : 7) == 0)
					held_left[b] = $urandom_range(1, 10);
			end
		end
		// occasional noise on the pins
		if ($urandom_range(0, 19) == 0)
			pins = 4'($urandom_range(0, 15));
	endtask

	// let every expected frame come out and the pipeline settle
	task automatic pause_until_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_frames.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// apb write of the debounce gap, then read it back
	task automatic write_gap(input logic [7:0] g);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GAP_ADDR;
		pwdata <= {24'd0, g};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		gap_cfg = g;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'd0, g}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("gap readback: expected %0d, got %0h", g, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// result side: compare each frame taken, then choose the next stall
	always @(posedge clk) begin
		scan_out_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			frames_checked++;
			if (due_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame: digit %0d segments %h set %b",
						digit_select, segments, set_mode_on);
			end else begin
				want = due_frames.pop_front();
				if (digit_select !== want.digit || segments !== want.seg ||
						set_mode_on !== want.setm) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame mismatch: expected digit %0d seg %h set %b, got %0d %h %b",
							want.digit, want.seg, want.setm,
							digit_select, segments, set_mode_on);
				end
			end
		end
		if (long_holds_done != long_holds_asked) begin
			long_holds_done++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus: directed rows, then four random phases
	initial begin
		int        i;
		int        ph;
		req_kind_t k;
		logic [31:0] t;
		logic [3:0]  pins;
		logic [7:0]  phase_gaps [4];
		int          phase_idle [4];
		int          phase_stall [4];
		phase_gaps = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), mbc_pkg::GAP_RESET};
		phase_idle = '{0, 73, 0, 25};
		phase_stall = '{0, 0, 73, 25};
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < DIRECTED_ROWS; i++)
			offer_request(DIRECTED[i].kind, DIRECTED[i].at_ms, DIRECTED[i].pins,
				DIRECTED[i].typed, DIRECTED[i].frame);
		for (ph = 0; ph < 4; ph++) begin
			pause_until_drained();
			write_gap(phase_gaps[ph]);
			send_idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			// long output hold while requests keep coming
			if (ph == 0)
				long_holds_asked++;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				next_random_request(k, t, pins);
				offer_request(k, t, pins, 1'b0, NO_FRAME);
			end
		end
		pause_until_drained();
		repeat (4)
			@(posedge clk);
		$display("covered %0d scans and %0d ticks, %0d display frames compared",
			scans_sent, ticks_sent, frames_checked);
		$display("debounce gaps 10, 0, 255, %0d, 10; one %0d-cycle output hold",
			phase_gaps[2], LONG_HOLD);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
